### hdl/multitaper_cross_spectrum_combiner_macros.svh
// ---------------------------------------------------------------------------
// multitaper_cross_spectrum_combiner_macros.svh
// Assertion helpers used by the combiner controller RTL. Expect clk and rst_n in scope.
// ---------------------------------------------------------------------------
`ifndef MULTITAPER_CROSS_SPECTRUM_COMBINER_MACROS_SVH
`define MULTITAPER_CROSS_SPECTRUM_COMBINER_MACROS_SVH

// same-cycle implication
`define MTCSC_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MTCSC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/mtcsc_pkg.sv
// ---------------------------------------------------------------------------
// mtcsc_pkg
// Widths, constants and controller/datapath interface types of the combiner.
// ---------------------------------------------------------------------------
`default_nettype none

package mtcsc_pkg;

  localparam int MAX_TAPERS_DEF = 16;
  localparam int COEF_WIDTH_DEF = 16;

  // input fields
  localparam int FIELD_W = 16;
  localparam int EIGEN_W = 16;

  // weights are Q0.16, one extra bit holds unit weight
  localparam int W_W = 17;
  localparam logic [W_W-1:0] UNIT_WEIGHT = 17'h10000;

  // products are brought to Q.30; shift amount is 2*COEF_WIDTH - PR_SCALE
  localparam int PR_W     = 33;
  localparam int PR_SCALE = 32;

  localparam int ACC_W   = 56;
  localparam int WSUM_W  = 24;
  localparam int WSQ_W   = 40;
  localparam int WSUM2_W = 2 * WSUM_W;

  localparam int SPEC_W = 40;
  localparam int DOF_W  = 15;
  localparam logic [SPEC_W-1:0] SPEC_MAX = {1'b0, {(SPEC_W-1){1'b1}}};
  localparam logic [SPEC_W-1:0] SPEC_MIN = {1'b1, {(SPEC_W-1){1'b0}}};
  localparam logic [DOF_W-1:0]  DOF_MAX  = '1;
  localparam int DOF_SHIFT = 9;

  localparam int RATE_W    = 16;
  localparam int RATE_FRAC = 16;
  localparam logic [RATE_W-1:0] RATE_RESET = '1;

  // serial divider; every quotient taken here stays below 2**DIV_Q_W
  localparam int DIV_NUM_W = 58;
  localparam int DIV_DEN_W = 40;
  localparam int DIV_Q_W   = 33;

  localparam int SCALE_PROD_W = DIV_Q_W + RATE_W;
  localparam int SCALE_W      = SCALE_PROD_W + 1 - RATE_FRAC;

  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 96;
  localparam int OUT_TUSER_W = 2;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  typedef logic reg_idx_t;
  localparam reg_idx_t REG_WEIGHT_MODE = 1'b0;
  localparam reg_idx_t REG_RATE        = 1'b1;

  typedef logic [1:0] sel_t;
  localparam sel_t SEL_RE  = 2'd0;
  localparam sel_t SEL_IM  = 2'd1;
  localparam sel_t SEL_DOF = 2'd2;

  typedef struct packed {
    logic in_load;
    logic mul_en;
    logic acc_en;
    logic res_init;
    logic div_start;
    sel_t div_sel;
    sel_t sel;
    logic scale_en;
    logic part_store;
    logic dof_store;
    logic res_load;
    logic clr;
  } ctrl_cmd_t;

  typedef struct packed {
    logic close;
    logic wsum_zero;
    logic div_busy;
    logic div_done;
    logic out_free;
  } ctrl_sts_t;

endpackage

`default_nettype wire

### hdl/multitaper_cross_spectrum_combiner.sv
// ---------------------------------------------------------------------------
// multitaper_cross_spectrum_combiner
// Combines the tapers of one frequency bin into a cross spectrum estimate.
// Input stream: one taper per request (x and y eigencoefficients, eigenvalue),
//   in_tlast closes the bin; a bin also closes at its MAX_TAPERS-th taper.
// Output stream: one request per bin with the weighted average conj(X)*Y
//   scaled by the rate reciprocal (Q9.30, saturated), degrees of freedom in
//   Q7.8 and the bad-weight and saturation flags.
// Intake: a taper is taken only in the idle or accumulate state, so the
//   accumulate stage of one taper overlaps the intake of the next.
// Closing: unless the weight sum is zero, the serial divider runs three
//   divisions with 33-bit quotients (real, imaginary, dof) in turn.
//   No taper is taken while they run.
// Stall: a finished result waits in the output register; the next bin's
//   tapers keep flowing, and only a second finished bin waits for the slot.
// Reset: accumulators cleared, weight_mode 0, rate_reciprocal 65535.
// Configuration is written only while no bin is open; the user is bound to this, the block does not enforce it.
// ---------------------------------------------------------------------------
`default_nettype none

module multitaper_cross_spectrum_combiner
  import mtcsc_pkg::*;
#(
  parameter int MAX_TAPERS = MAX_TAPERS_DEF,
  parameter int COEF_WIDTH = COEF_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // coef_x_re, coef_x_im, coef_y_re, coef_y_im, eigenvalue (16 bits each)
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  input  wire logic                   in_tlast,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // spec_re (40), spec_im (40), dof (15), one pad bit
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  // bad_weights, saturated
  output logic [OUT_TUSER_W-1:0]      out_tuser,
  input  wire logic                   cfg_psel,
  input  wire logic                   cfg_penable,
  input  wire logic                   cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0]  cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [CFG_DATA_W-1:0]       cfg_prdata,
  output logic                        cfg_pready
);

  logic              weight_mode_r;
  logic [RATE_W-1:0] rate_r;
  logic              cfg_wr;
  reg_idx_t          cfg_idx;
  ctrl_cmd_t         cmd;
  ctrl_sts_t         sts;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_mode_r <= 1'b0;
      rate_r        <= RATE_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_WEIGHT_MODE: weight_mode_r <= cfg_pwdata[0];
        REG_RATE:        rate_r        <= cfg_pwdata[RATE_W-1:0];
        default: begin
          weight_mode_r <= weight_mode_r;
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_WEIGHT_MODE: cfg_prdata = CFG_DATA_W'(weight_mode_r);
      REG_RATE:        cfg_prdata = CFG_DATA_W'(rate_r);
      default:         cfg_prdata = '0;
    endcase
  end

  mtcsc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mtcsc_dp #(
    .MAX_TAPERS (MAX_TAPERS),
    .COEF_WIDTH (COEF_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_tdata        (in_tdata),
    .in_tlast        (in_tlast),
    .weight_mode     (weight_mode_r),
    .rate_reciprocal (rate_r),
    .out_tready      (out_tready),
    .out_tvalid      (out_tvalid),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser)
  );

endmodule

`default_nettype wire

### hdl/mtcsc_div.sv
// ---------------------------------------------------------------------------
// mtcsc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module mtcsc_div
  import mtcsc_pkg::*;
#(
  parameter int NUM_W = DIV_NUM_W,
  parameter int DEN_W = DIV_DEN_W,
  parameter int Q_W   = DIV_Q_W
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  busy,
  output logic                  done,
  output logic [Q_W-1:0]        quot
);

  localparam int CNT_W = $clog2(Q_W + 1);

  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r;
  logic [Q_W-1:0]   quo_r, quo_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   diff;
  logic             ge;

  // quotient bits enter quo_r from the bottom as dividend bits leave the top
  assign shifted = {rem_r, quo_r[Q_W-1]};
  assign ge      = shifted >= {1'b0, den_r};
  assign diff    = shifted - {1'b0, den_r};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = DEN_W'(num[NUM_W-1:Q_W]);
      quo_nxt  = num[Q_W-1:0];
      cnt_nxt  = CNT_W'(Q_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      quo_nxt = {quo_r[Q_W-2:0], ge};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      den_r <= den;
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = quo_r;

endmodule

`default_nettype wire

### hdl/mtcsc_ctrl.sv
// ---------------------------------------------------------------------------
// mtcsc_ctrl
// Sequencer: taper intake, then the closing divisions and result hand-off.
// ---------------------------------------------------------------------------
`default_nettype none
`include "multitaper_cross_spectrum_combiner_macros.svh"

module mtcsc_ctrl
  import mtcsc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_tvalid,
  output logic           in_tready,
  input  wire ctrl_sts_t sts,
  output ctrl_cmd_t      cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MUL    = 4'd1;
  localparam logic [3:0] S_ACC    = 4'd2;
  localparam logic [3:0] S_CLOSE  = 4'd3;
  localparam logic [3:0] S_DIV    = 4'd4;
  localparam logic [3:0] S_SCALE  = 4'd5;
  localparam logic [3:0] S_PART   = 4'd6;
  localparam logic [3:0] S_DOFEND = 4'd7;
  localparam logic [3:0] S_OUT    = 4'd8;

  logic [3:0] state_r, state_nxt;
  sel_t       sel_r, sel_nxt;

  always_comb begin
    state_nxt   = state_r;
    sel_nxt     = sel_r;
    cmd         = '0;
    cmd.sel     = sel_r;
    cmd.div_sel = sel_r;
    in_tready   = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.in_load = 1'b1;
          state_nxt   = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = S_ACC;
      end
      S_ACC: begin
        cmd.acc_en = 1'b1;
        if (sts.close) begin
          state_nxt = S_CLOSE;
        end else begin
          // take the next taper while this one accumulates
          in_tready = 1'b1;
          if (in_tvalid) begin
            cmd.in_load = 1'b1;
            state_nxt   = S_MUL;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_CLOSE: begin
        cmd.res_init = 1'b1;
        if (sts.wsum_zero) begin
          state_nxt = S_OUT;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = SEL_RE;
          sel_nxt       = SEL_RE;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_nxt = (sel_r == SEL_DOF) ? S_DOFEND : S_SCALE;
        end
      end
      S_SCALE: begin
        cmd.scale_en = 1'b1;
        state_nxt    = S_PART;
      end
      S_PART: begin
        cmd.part_store = 1'b1;
        cmd.div_start  = 1'b1;
        sel_nxt        = (sel_r == SEL_RE) ? SEL_IM : SEL_DOF;
        cmd.div_sel    = sel_nxt;
        state_nxt      = S_DIV;
      end
      S_DOFEND: begin
        cmd.dof_store = 1'b1;
        state_nxt     = S_OUT;
      end
      S_OUT: begin
        // hold until the output register can take the result
        if (sts.out_free) begin
          cmd.res_load = 1'b1;
          cmd.clr      = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sel_r   <= SEL_RE;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
    end
  end

  `MTCSC_ASSERT_NEXT(a_accept_enters_mul, in_tvalid && in_tready, state_r == S_MUL, "accepted request did not enter multiply")
  `MTCSC_ASSERT_IMPL(a_start_when_free, cmd.div_start, !sts.div_busy, "divider restarted while busy")
  `MTCSC_ASSERT_IMPL(a_done_in_div, sts.div_done, state_r == S_DIV, "divider finished outside wait state")
  `MTCSC_ASSERT_IMPL(a_no_intake_while_div, sts.div_busy, !in_tready, "request taken during closing divide")

endmodule

`default_nettype wire

### hdl/mtcsc_dp.sv
// ---------------------------------------------------------------------------
// mtcsc_dp
// Datapath: cross product, weighted accumulation, closing scale and output
// register.
// ---------------------------------------------------------------------------
`default_nettype none

module mtcsc_dp
  import mtcsc_pkg::*;
#(
  parameter int MAX_TAPERS = MAX_TAPERS_DEF,
  parameter int COEF_WIDTH = COEF_WIDTH_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire ctrl_cmd_t               cmd,
  output ctrl_sts_t                    sts,
  input  wire logic [IN_TDATA_W-1:0]   in_tdata,
  input  wire logic                    in_tlast,
  input  wire logic                    weight_mode,
  input  wire logic [RATE_W-1:0]       rate_reciprocal,
  input  wire logic                    out_tready,
  output logic                         out_tvalid,
  output logic [OUT_TDATA_W-1:0]       out_tdata,
  output logic [OUT_TUSER_W-1:0]       out_tuser
);

  localparam int IN_TAKE = (COEF_WIDTH < FIELD_W) ? COEF_WIDTH : FIELD_W;
  localparam int PROD_W  = 2 * COEF_WIDTH + 1;
  localparam int SHR     = (2 * COEF_WIDTH > PR_SCALE) ? 2 * COEF_WIDTH - PR_SCALE : 0;
  localparam int SHL     = (2 * COEF_WIDTH < PR_SCALE) ? PR_SCALE - 2 * COEF_WIDTH : 0;
  localparam int EXT_W   = PROD_W + SHL;
  localparam int CNT_W   = $clog2(MAX_TAPERS + 1);
  localparam int WPROD_W = W_W + PR_W + 1;

  // input stage
  logic signed [COEF_WIDTH-1:0] xr_r, xi_r, yr_r, yi_r;
  logic [W_W-1:0]               w_r;
  logic                         last_r;

  // product stage
  logic signed [PROD_W-1:0] prod_re, prod_im;
  logic signed [EXT_W-1:0]  ext_re, ext_im;
  logic signed [PR_W-1:0]   pr_r, pi_r;
  logic [W_W-1:0]           w2_r;
  logic                     last2_r;

  // accumulation
  logic signed [WPROD_W-1:0] wprod_re, wprod_im;
  logic [2*W_W-1:0]          wsqr;
  logic signed [ACC_W-1:0]   acc_re_r, acc_re_nxt, acc_im_r, acc_im_nxt;
  logic [WSUM_W-1:0]         wsum_r, wsum_nxt;
  logic [WSQ_W-1:0]          wsq_r, wsq_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic [WSUM2_W-1:0]        wsum2_r;

  // closing
  logic [ACC_W-1:0]          mag_re, mag_im;
  logic [DIV_NUM_W-1:0]      div_num;
  logic [DIV_DEN_W-1:0]      div_den;
  logic                      div_busy, div_done;
  logic [DIV_Q_W-1:0]        quot;
  logic [SCALE_PROD_W:0]     scale_sum;
  logic [SCALE_W-1:0]        s_r;
  logic                      neg_cur;
  logic [SPEC_W:0]           s_ext, s_limit;
  logic                      over;
  logic [SPEC_W-1:0]         s_spec, part_val;
  logic [SPEC_W-1:0]         spec_re_r, spec_im_r;
  logic [DOF_W-1:0]          dof_r;
  logic                      sat_r, bad_r;

  // output register
  logic                      out_valid_r;
  logic [OUT_TDATA_W-1:0]    out_data_r;
  logic [OUT_TUSER_W-1:0]    out_user_r;

  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      xr_r   <= COEF_WIDTH'(in_tdata[0*FIELD_W +: IN_TAKE]);
      xi_r   <= COEF_WIDTH'(in_tdata[1*FIELD_W +: IN_TAKE]);
      yr_r   <= COEF_WIDTH'(in_tdata[2*FIELD_W +: IN_TAKE]);
      yi_r   <= COEF_WIDTH'(in_tdata[3*FIELD_W +: IN_TAKE]);
      w_r    <= weight_mode ? UNIT_WEIGHT : W_W'(in_tdata[4*FIELD_W +: EIGEN_W]);
      last_r <= in_tlast;
    end
  end

  // conj(X) * Y, then align to Q.30 with floor
  assign prod_re = PROD_W'(xr_r * yr_r) + PROD_W'(xi_r * yi_r);
  assign prod_im = PROD_W'(xr_r * yi_r) - PROD_W'(xi_r * yr_r);
  assign ext_re  = EXT_W'(prod_re);
  assign ext_im  = EXT_W'(prod_im);

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      pr_r    <= PR_W'((ext_re <<< SHL) >>> SHR);
      pi_r    <= PR_W'((ext_im <<< SHL) >>> SHR);
      w2_r    <= w_r;
      last2_r <= last_r;
    end
  end

  assign wprod_re = $signed({1'b0, w2_r}) * pr_r;
  assign wprod_im = $signed({1'b0, w2_r}) * pi_r;
  assign wsqr     = w2_r * w2_r;

  always_comb begin
    acc_re_nxt = acc_re_r;
    acc_im_nxt = acc_im_r;
    wsum_nxt   = wsum_r;
    wsq_nxt    = wsq_r;
    cnt_nxt    = cnt_r;
    if (cmd.clr) begin
      acc_re_nxt = '0;
      acc_im_nxt = '0;
      wsum_nxt   = '0;
      wsq_nxt    = '0;
      cnt_nxt    = '0;
    end else if (cmd.acc_en) begin
      acc_re_nxt = acc_re_r + ACC_W'(wprod_re);
      acc_im_nxt = acc_im_r + ACC_W'(wprod_im);
      wsum_nxt   = wsum_r + WSUM_W'(w2_r);
      wsq_nxt    = wsq_r + WSQ_W'(wsqr);
      cnt_nxt    = cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_re_r <= '0;
      acc_im_r <= '0;
      wsum_r   <= '0;
      wsq_r    <= '0;
      cnt_r    <= '0;
    end else begin
      acc_re_r <= acc_re_nxt;
      acc_im_r <= acc_im_nxt;
      wsum_r   <= wsum_nxt;
      wsq_r    <= wsq_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // settles long before the degrees-of-freedom divide starts
  always_ff @(posedge clk) begin
    wsum2_r <= wsum_r * wsum_r;
  end

  assign mag_re = acc_re_r[ACC_W-1] ? -acc_re_r : acc_re_r;
  assign mag_im = acc_im_r[ACC_W-1] ? -acc_im_r : acc_im_r;

  always_comb begin
    case (cmd.div_sel)
      SEL_RE: begin
        div_num = DIV_NUM_W'(mag_re) + DIV_NUM_W'(wsum_r >> 1);
        div_den = DIV_DEN_W'(wsum_r);
      end
      SEL_IM: begin
        div_num = DIV_NUM_W'(mag_im) + DIV_NUM_W'(wsum_r >> 1);
        div_den = DIV_DEN_W'(wsum_r);
      end
      SEL_DOF: begin
        div_num = (DIV_NUM_W'(wsum2_r) << DOF_SHIFT) + DIV_NUM_W'(wsq_r >> 1);
        div_den = wsq_r;
      end
      default: begin
        div_num = '0;
        div_den = '0;
      end
    endcase
  end

  mtcsc_div #(
    .NUM_W (DIV_NUM_W),
    .DEN_W (DIV_DEN_W),
    .Q_W   (DIV_Q_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (quot)
  );

  // rate scaling, round half away from zero on the magnitude
  assign scale_sum = (SCALE_PROD_W + 1)'(quot * rate_reciprocal)
                   + ((SCALE_PROD_W + 1)'(1) << (RATE_FRAC - 1));

  always_ff @(posedge clk) begin
    if (cmd.scale_en) begin
      s_r <= scale_sum[SCALE_PROD_W:RATE_FRAC];
    end
  end

  assign neg_cur  = (cmd.sel == SEL_IM) ? acc_im_r[ACC_W-1] : acc_re_r[ACC_W-1];
  assign s_ext    = (SPEC_W + 1)'(s_r);
  assign s_limit  = (SPEC_W + 1)'(SPEC_MAX) + (SPEC_W + 1)'(neg_cur);
  assign over     = s_ext > s_limit;
  assign s_spec   = SPEC_W'(s_r);
  assign part_val = over ? (neg_cur ? SPEC_MIN : SPEC_MAX)
                         : (neg_cur ? -s_spec : s_spec);

  always_ff @(posedge clk) begin
    if (cmd.res_init) begin
      spec_re_r <= '0;
      spec_im_r <= '0;
      dof_r     <= '0;
      sat_r     <= 1'b0;
      bad_r     <= (wsum_r == '0);
    end else begin
      if (cmd.part_store) begin
        if (cmd.sel == SEL_IM) begin
          spec_im_r <= part_val;
        end else begin
          spec_re_r <= part_val;
        end
        sat_r <= sat_r | over;
      end
      if (cmd.dof_store) begin
        dof_r <= (quot > DIV_Q_W'(DOF_MAX)) ? DOF_MAX : quot[DOF_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_data_r <= OUT_TDATA_W'({dof_r, spec_im_r, spec_re_r});
      out_user_r <= {sat_r, bad_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  assign sts.close     = last2_r || (cnt_r == CNT_W'(MAX_TAPERS - 1));
  assign sts.wsum_zero = (wsum_r == '0);
  assign sts.div_busy  = div_busy;
  assign sts.div_done  = div_done;
  assign sts.out_free  = !out_valid_r || out_tready;

endmodule

`default_nettype wire
